// ===== src/lsf_pkg.sv =====
package lsf_pkg;

  // Field widths of one beat.
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  // Coefficients carry 12 fractional bits, so products sit 12 bits above Q23.8.
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

  // Command carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_COEF = 2'd0,
    CMD_FILTER    = 2'd1,
    CMD_LOAD_HIST = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_e;

endpackage

// ===== src/lsf_ram.sv =====
module lsf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lpc_synthesis_filter_top.sv =====
// All-pole LPC synthesis filter, fixed point.
// Input channel (s_axis): tuser carries the command, tdata the index, the
// Q3.12 coefficient and the Q23.8 sample. While idle, a coefficient or history
// load takes one beat per cycle and produces no output. A filter beat computes
// y = x - sum a[k]*y[n-k] over FILTER_ORDER taps, rounds, saturates to 32 bits,
// pushes y into the history and emits one output beat.
// Output channel (m_axis): tdata is the sample, tuser is the saturation flag.
// A filter beat closes the input through the ST_RUN, ST_WAIT and ST_FINISH
// states, so no new sample is taken before the last result is loaded into the
// output register. The single multiply-accumulate walks the taps one per cycle
// from the coefficient and history memories, each read through its one read
// port.
// Reset clears all coefficients and history to zero through per-entry valid
// bits; no clearing pass is needed. If the receiver stalls, the result holds
// in the output register while loads and a further filter beat are still
// taken; that next filter result waits at its last step until the output
// register frees up.
module lpc_synthesis_filter_top import lsf_pkg::*; #(
  parameter int unsigned FILTER_ORDER = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] index, [19:4] coef_value, [51:20] sample_in, [55:52] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] sample_out
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output logic                  m_axis_tuser
);

  localparam int unsigned AW    = $clog2(FILTER_ORDER);
  localparam int unsigned ACC_W = PROD_W + $clog2(FILTER_ORDER) + 1;

  // Input fields.
  logic [INDEX_W-1:0]         in_index;
  logic signed [COEF_W-1:0]   in_coef;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_beat;
  logic                       idx_ok;
  logic [AW:0]                idx_a;

  assign in_index  = s_axis_tdata[INDEX_W-1:0];
  assign in_coef   = s_axis_tdata[INDEX_W +: COEF_W];
  assign in_sample = s_axis_tdata[INDEX_W+COEF_W +: SAMPLE_W];
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign idx_ok    = ({28'd0, in_index} < 32'(FILTER_ORDER));
  assign idx_a     = (AW+1)'(in_index);

  // Control and datapath registers.
  state_e                     state_q, state_d;
  logic [AW-1:0]              tap_q, tap_d;
  logic [AW-1:0]              base_q, base_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       rd_vld_q, rd_vld_d, rd_last_q, rd_last_d;
  logic                       prod_vld_q, prod_last_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [FILTER_ORDER-1:0]    cvld_q, cvld_d, hvld_q, hvld_d;
  logic                       cmask_q, hmask_q;
  logic                       out_vld_q, out_vld_d;
  logic [OUT_DATA_W-1:0]      out_data_q, out_data_d;
  logic                       out_sat_q, out_sat_d;

  // Memory ports.
  logic                       coef_we, hist_we;
  logic [AW-1:0]              coef_waddr, hist_waddr, coef_raddr, hist_raddr;
  logic [COEF_W-1:0]          coef_wdata, coef_rdata;
  logic [SAMPLE_W-1:0]        hist_wdata, hist_rdata;

  // Circular history: lag i lives at (base + i) mod FILTER_ORDER.
  logic [AW:0]                tap_sum, load_sum;
  logic [AW-1:0]              tap_addr, load_addr, base_m1;

  assign tap_sum   = {1'b0, base_q} + {1'b0, tap_q};
  assign tap_addr  = (tap_sum >= (AW+1)'(FILTER_ORDER)) ?
                     AW'(tap_sum - (AW+1)'(FILTER_ORDER)) : AW'(tap_sum);
  assign load_sum  = {1'b0, base_q} + idx_a;
  assign load_addr = (load_sum >= (AW+1)'(FILTER_ORDER)) ?
                     AW'(load_sum - (AW+1)'(FILTER_ORDER)) : AW'(load_sum);
  assign base_m1   = (base_q == '0) ? AW'(FILTER_ORDER - 1) : AW'(base_q - 1'b1);

  // Rounding and saturation of the finished accumulator.
  logic signed [ACC_W-1:0]    acc_rnd, acc_shr;
  logic                       clip;
  logic [OUT_DATA_W-1:0]      y_val;

  assign acc_rnd = acc_q + ACC_W'(2048);
  assign acc_shr = acc_rnd >>> FRAC_SHIFT;
  assign clip    = !((&acc_shr[ACC_W-1:SAMPLE_W-1]) || !(|acc_shr[ACC_W-1:SAMPLE_W-1]));
  assign y_val   = !clip ? acc_shr[SAMPLE_W-1:0] :
                   (acc_rnd[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff);

  // Tap product with never-written entries reading as zero.
  logic signed [COEF_W-1:0]   coef_eff;
  logic signed [SAMPLE_W-1:0] hist_eff;

  assign coef_eff = cmask_q ? signed'(coef_rdata) : '0;
  assign hist_eff = hmask_q ? signed'(hist_rdata) : '0;

  assign coef_raddr = tap_q;
  assign hist_raddr = tap_addr;

  // Sequencer: next state, memory writes and output register loads.
  always_comb begin
    state_d    = state_q;
    tap_d      = tap_q;
    base_d     = base_q;
    acc_d      = acc_q;
    rd_vld_d   = 1'b0;
    rd_last_d  = 1'b0;
    cvld_d     = cvld_q;
    hvld_d     = hvld_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_sat_d  = out_sat_q;
    coef_we    = 1'b0;
    coef_waddr = AW'(idx_a);
    coef_wdata = in_coef;
    hist_we    = 1'b0;
    hist_waddr = load_addr;
    hist_wdata = in_sample;
    s_axis_tready = 1'b0;

    if (prod_vld_q) begin
      acc_d = acc_q - ACC_W'(prod_q);
    end

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_beat) begin
          unique case (s_axis_tuser)
            CMD_LOAD_COEF: begin
              if (idx_ok) begin
                coef_we = 1'b1;
                cvld_d[AW'(idx_a)] = 1'b1;
              end
            end
            CMD_LOAD_HIST: begin
              if (idx_ok) begin
                hist_we = 1'b1;
                hvld_d[load_addr] = 1'b1;
              end
            end
            CMD_FILTER: begin
              acc_d   = {{(ACC_W-SAMPLE_W-FRAC_SHIFT){in_sample[SAMPLE_W-1]}},
                         in_sample, {FRAC_SHIFT{1'b0}}};
              tap_d   = '0;
              state_d = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_vld_d = 1'b1;
        if (tap_q == AW'(FILTER_ORDER - 1)) begin
          rd_last_d = 1'b1;
          state_d   = ST_WAIT;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (prod_vld_q && prod_last_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          hist_we    = 1'b1;
          hist_waddr = base_m1;
          hist_wdata = y_val;
          hvld_d[base_m1] = 1'b1;
          base_d     = base_m1;
          out_vld_d  = 1'b1;
          out_data_d = y_val;
          out_sat_d  = clip;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      base_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      cvld_q      <= '0;
      hvld_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      base_q      <= base_d;
      rd_vld_q    <= rd_vld_d;
      rd_last_q   <= rd_last_d;
      prod_vld_q  <= rd_vld_q;
      prod_last_q <= rd_last_q;
      cvld_q      <= cvld_d;
      hvld_q      <= hvld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    prod_q     <= coef_eff * hist_eff;
    cmask_q    <= cvld_q[coef_raddr];
    hmask_q    <= hvld_q[hist_raddr];
    out_data_q <= out_data_d;
    out_sat_q  <= out_sat_d;
  end

  // Coefficient memory, entry i holds a[i+1].
  lsf_ram #(
    .WIDTH(COEF_W),
    .DEPTH(FILTER_ORDER)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(coef_waddr),
    .wdata_i(coef_wdata),
    .raddr_i(coef_raddr),
    .rdata_o(coef_rdata)
  );

  // History memory, addressed as a ring around base_q.
  lsf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(FILTER_ORDER)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(hist_waddr),
    .wdata_i(hist_wdata),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule

// ===== src/lsf_checker.sv =====
module lsf_checker import lsf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [CMD_W-1:0]      s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled output beat holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // A filter beat closes the input while the taps are processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && s_axis_tuser == CMD_FILTER |=> !s_axis_tready)
    else $error("input open during filtering");

  // Loads into an idle block never raise an output beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && s_axis_tuser != CMD_FILTER && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output beat without a filter command");

  // A clipped result sits at one end of the range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000)
    else $error("saturation flag with unclipped sample");

endmodule

bind lpc_synthesis_filter_top lsf_checker u_lsf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
